[rtl/core/sidec_pkg.sv]
// Shared constants, state encoding and control/status bundles for the decimal text converter.
package sidec_pkg;

  localparam int DATA_WIDTH_DEF = 32;

  localparam logic [7:0] CH_ZERO  = 8'd48;
  localparam logic [7:0] CH_MINUS = 8'd45;
  localparam logic [7:0] CH_NINE  = 8'd57;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_SIGN,
    ST_EMIT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic shift;
    logic emit_sign;
    logic emit_digit;
  } dp_cmd_t;

  // Status from the datapath back to the controller.
  typedef struct packed {
    logic shift_last;
    logic neg;
    logic digit_last;
  } dp_stat_t;

endpackage

[rtl/core/signed_int_to_decimal_ascii.sv]
// Top level: signed integer to decimal ASCII character stream.
// The first character reaches the outputs through the output register once the conversion
//   loop is done. A new request is accepted only after the previous run has ended;
//   the bit-serial shift-add-3 conversion loop handles one magnitude bit per cycle.
// Reset (rst_n low, synchronous) returns the sequencer to idle and drops out_valid.
// Characters leave on a strobe, one per cycle; the receiver cannot stall.
module signed_int_to_decimal_ascii #(
  parameter int DATA_WIDTH = sidec_pkg::DATA_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // request channel: accepted when start is high and busy is low
  input  logic                         start,
  output logic                         busy,
  input  logic signed [DATA_WIDTH-1:0] in_value,
  // character channel: one character per out_valid cycle, MSB digit first
  output logic                         out_valid,
  output logic [7:0]                   out_char_code,
  output logic                         out_last_char
);

  // Controller and datapath talk only through these two bundles.
  sidec_pkg::dp_cmd_t  cmd;
  sidec_pkg::dp_stat_t stat;

  // Sequencer: idle -> convert -> sign if negative -> digits.
  sidec_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  // Datapath: magnitude is formed unsigned, so the most negative value is exact.
  // The significant-digit count is tracked during conversion, so leading
  // zeros are never emitted and no skip cycles are spent.
  sidec_dp #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_value      (in_value),
    .cmd           (cmd),
    .stat          (stat),
    .out_valid     (out_valid),
    .out_char_code (out_char_code),
    .out_last_char (out_last_char)
  );

endmodule

[rtl/core/sidec_ctrl.sv]
// Sequencer: load, bit-serial conversion, optional sign, digit emission.
module sidec_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  sidec_pkg::dp_stat_t stat,
  output sidec_pkg::dp_cmd_t  cmd
);

  sidec_pkg::state_t state_r;
  sidec_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sidec_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    busy      = 1'b1;
    case (state_r)
      sidec_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = sidec_pkg::ST_CONV;
        end
      end
      sidec_pkg::ST_CONV: begin
        cmd.shift = 1'b1;
        if (stat.shift_last) begin
          state_nxt = stat.neg ? sidec_pkg::ST_SIGN : sidec_pkg::ST_EMIT;
        end
      end
      sidec_pkg::ST_SIGN: begin
        cmd.emit_sign = 1'b1;
        state_nxt     = sidec_pkg::ST_EMIT;
      end
      sidec_pkg::ST_EMIT: begin
        cmd.emit_digit = 1'b1;
        if (stat.digit_last) begin
          state_nxt = sidec_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = sidec_pkg::ST_IDLE;
      end
    endcase
  end

`ifndef NO_ASSERTIONS
  a_accept_starts_conv: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == sidec_pkg::ST_IDLE && start) |=> state_r == sidec_pkg::ST_CONV)
    else $error("accepted request did not enter conversion");

  a_last_digit_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == sidec_pkg::ST_EMIT && stat.digit_last) |=> state_r == sidec_pkg::ST_IDLE)
    else $error("run did not end after last digit");

  a_sign_only_neg: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == sidec_pkg::ST_SIGN |-> stat.neg)
    else $error("sign emitted for non-negative request");
`endif

endmodule

[rtl/core/sidec_dp.sv]
// Datapath: magnitude, shift-add-3 BCD register, digit count and output register.
module sidec_dp #(
  parameter int DATA_WIDTH = sidec_pkg::DATA_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic signed [DATA_WIDTH-1:0] in_value,
  input  sidec_pkg::dp_cmd_t           cmd,
  output sidec_pkg::dp_stat_t          stat,
  output logic                         out_valid,
  output logic [7:0]                   out_char_code,
  output logic                         out_last_char
);

  // Decimal digits of 2^DATA_WIDTH - 1 (1233/4096 ~ log10 2).
  localparam int ND    = (DATA_WIDTH * 1233) / 4096 + 1;
  localparam int IDX_W = $clog2(ND);
  localparam int CNT_W = $clog2(ND + 1);
  localparam int BIT_W = $clog2(DATA_WIDTH + 1);

  logic [DATA_WIDTH-1:0]  mag_r;
  logic                   neg_r;
  logic [ND-1:0][3:0]     bcd_r;
  logic [ND-1:0][3:0]     bcd_adj;
  logic [4*ND:0]          bcd_shift;
  logic [ND-1:0][3:0]     bcd_nxt;
  logic [CNT_W-1:0]       cnt_r;
  logic [CNT_W-1:0]       cnt_nxt;
  logic [BIT_W-1:0]       bit_cnt_r;
  logic [IDX_W-1:0]       emit_idx_r;
  logic [IDX_W-1:0]       probe_idx;
  logic                   out_valid_r;
  logic [7:0]             out_char_r;
  logic                   out_last_r;

  // add 3 to every digit >= 5, then shift one magnitude bit in
  always_comb begin
    for (int i = 0; i < ND; i++) begin
      bcd_adj[i] = (bcd_r[i] >= 4'd5) ? bcd_r[i] + 4'd3 : bcd_r[i];
    end
    // top bit never set: the value always fits in ND digits
    bcd_shift = {bcd_adj, mag_r[DATA_WIDTH-1]};
    bcd_nxt   = bcd_shift[4*ND-1:0];
  end

  // Leading digit can only advance by one position per doubling.
  assign probe_idx = cnt_r[IDX_W-1:0];
  always_comb begin
    cnt_nxt = cnt_r;
    if (cnt_r < CNT_W'(ND) && bcd_nxt[probe_idx] != 4'd0) begin
      cnt_nxt = cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      neg_r     <= in_value[DATA_WIDTH-1];
      mag_r     <= in_value[DATA_WIDTH-1] ? (~in_value + 1'b1) : in_value;
      bcd_r     <= '0;
      cnt_r     <= '0;
      bit_cnt_r <= BIT_W'(DATA_WIDTH);
    end else if (cmd.shift) begin
      mag_r      <= {mag_r[DATA_WIDTH-2:0], 1'b0};
      bcd_r      <= bcd_nxt;
      cnt_r      <= cnt_nxt;
      bit_cnt_r  <= bit_cnt_r - 1'b1;
      emit_idx_r <= (cnt_nxt == '0) ? '0 : IDX_W'(cnt_nxt - 1'b1);
    end else if (cmd.emit_digit && emit_idx_r != '0) begin
      emit_idx_r <= emit_idx_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit_sign | cmd.emit_digit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_sign) begin
      out_char_r <= sidec_pkg::CH_MINUS;
      out_last_r <= 1'b0;
    end else if (cmd.emit_digit) begin
      out_char_r <= sidec_pkg::CH_ZERO + {4'd0, bcd_r[emit_idx_r]};
      out_last_r <= (emit_idx_r == '0);
    end
  end

  assign stat.shift_last = (bit_cnt_r == BIT_W'(1));
  assign stat.neg        = neg_r;
  assign stat.digit_last = (emit_idx_r == '0);

  assign out_valid     = out_valid_r;
  assign out_char_code = out_char_r;
  assign out_last_char = out_last_r;

`ifndef NO_ASSERTIONS
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit_digit |-> (int'(cnt_r) <= ND && int'(emit_idx_r) < ND))
    else $error("digit count out of range");

  a_char_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_char_r == sidec_pkg::CH_MINUS ||
                     (out_char_r >= sidec_pkg::CH_ZERO && out_char_r <= sidec_pkg::CH_NINE)))
    else $error("illegal character emitted");

  a_gap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_last_r) |=> !out_valid_r)
    else $error("character emitted right after end of run");
`endif

endmodule
